/* sv/pars_pkg.sv */
// Shared types and constants for the pulse actuator request scheduler.
package pars_pkg;

  localparam int TICKS_W = 16;
  localparam int ACT_W   = 2;
  localparam int MASK_W  = 4;

  localparam logic [TICKS_W-1:0] PULSE_TICKS_RST = 16'd50;

  // Command field codes of an input request.
  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  // Controller to datapath command.
  typedef struct packed {
    logic step;  // apply the accepted request this cycle
    logic tick;  // the accepted request is a time tick
  } pars_cmd_t;

endpackage

/* sv/pars_ctrl.sv */
// Controller: output occupancy state machine and request acceptance.
module pars_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  output logic                out_valid,
  input  logic                out_ready,
  output pars_pkg::pars_cmd_t dp_cmd
);

  typedef enum logic {
    ST_EMPTY,
    ST_FULL
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  // A new request may enter while the held result is being taken.
  assign in_ready  = (state_r == ST_EMPTY) || out_ready;
  assign out_valid = (state_r == ST_FULL);
  assign accept    = in_valid && in_ready;

  assign dp_cmd.step = accept;
  assign dp_cmd.tick = (in_cmd == pars_pkg::CMD_TICK);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_EMPTY: begin
        if (accept) begin
          state_nxt = ST_FULL;
        end
      end
      ST_FULL: begin
        if (out_ready && !accept) begin
          state_nxt = ST_EMPTY;
        end
      end
      default: state_nxt = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* sv/pars_dp.sv */
// Datapath: pending slots, pulse timer, drive registers and pulse length register.
module pars_dp #(
  parameter int NUM_ACTUATORS = 4
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  pars_pkg::pars_cmd_t                    dp_cmd,
  input  logic [pars_pkg::ACT_W-1:0]             in_actuator,
  input  logic                                   in_target_position,
  input  logic                                   cfg_wr,
  input  logic [pars_pkg::TICKS_W-1:0]           cfg_data,
  output logic                                   drive_enable,
  output logic [pars_pkg::ACT_W-1:0]             drive_address,
  output logic                                   drive_position,
  output logic [pars_pkg::MASK_W-1:0]            pending_mask
);

  logic [pars_pkg::TICKS_W-1:0] pulse_ticks_r;
  logic [pars_pkg::TICKS_W-1:0] ticks_r, ticks_nxt, ticks_dec;
  logic [NUM_ACTUATORS-1:0]     pend_r, pend_nxt;
  logic [NUM_ACTUATORS-1:0]     ppos_r, ppos_nxt;
  logic [pars_pkg::ACT_W-1:0]   cur_act_r, cur_act_nxt;
  logic                         cur_pos_r, cur_pos_nxt;
  logic                         en_r, en_nxt;
  logic                         found;
  logic [pars_pkg::ACT_W-1:0]   pick_act;
  logic                         pick_pos;
  logic [NUM_ACTUATORS-1:0]     pick_onehot;
  logic                         drop;

  assign ticks_dec = (ticks_r != '0) ? ticks_r - pars_pkg::TICKS_W'(1) : '0;

  // Lowest-numbered pending slot wins.
  always_comb begin
    found       = 1'b0;
    pick_act    = '0;
    pick_pos    = 1'b0;
    pick_onehot = '0;
    for (int i = 0; i < NUM_ACTUATORS; i++) begin
      if (pend_r[i] && !found) begin
        found          = 1'b1;
        pick_act       = pars_pkg::ACT_W'(i);
        pick_pos       = ppos_r[i];
        pick_onehot[i] = 1'b1;
      end
    end
  end

  // A request equal to the running pulse is dropped.
  assign drop = (ticks_r != '0) && (in_actuator == cur_act_r) &&
                (in_target_position == cur_pos_r);

  always_comb begin
    ticks_nxt   = ticks_r;
    pend_nxt    = pend_r;
    ppos_nxt    = ppos_r;
    cur_act_nxt = cur_act_r;
    cur_pos_nxt = cur_pos_r;
    en_nxt      = en_r;
    if (dp_cmd.step) begin
      if (dp_cmd.tick) begin
        if (ticks_dec != '0) begin
          ticks_nxt = ticks_dec;
        end else if (found) begin
          pend_nxt    = pend_r & ~pick_onehot;
          cur_act_nxt = pick_act;
          cur_pos_nxt = pick_pos;
          ticks_nxt   = pulse_ticks_r;
          en_nxt      = 1'b1;
        end else begin
          ticks_nxt = '0;
          en_nxt    = 1'b0;
        end
      end else if (!drop) begin
        for (int i = 0; i < NUM_ACTUATORS; i++) begin
          if (in_actuator == pars_pkg::ACT_W'(i)) begin
            pend_nxt[i] = 1'b1;
            ppos_nxt[i] = in_target_position;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_ticks_r <= pars_pkg::PULSE_TICKS_RST;
      ticks_r       <= '0;
      pend_r        <= '0;
      cur_act_r     <= '0;
      cur_pos_r     <= 1'b0;
      en_r          <= 1'b0;
    end else begin
      if (cfg_wr) begin
        pulse_ticks_r <= cfg_data;
      end
      ticks_r   <= ticks_nxt;
      pend_r    <= pend_nxt;
      cur_act_r <= cur_act_nxt;
      cur_pos_r <= cur_pos_nxt;
      en_r      <= en_nxt;
    end
  end

  // Positions are only read behind a set pending flag.
  always_ff @(posedge clk) begin
    ppos_r <= ppos_nxt;
  end

  assign drive_enable   = en_r;
  assign drive_address  = cur_act_r;
  assign drive_position = cur_pos_r;
  assign pending_mask   = pars_pkg::MASK_W'(pend_r);

endmodule

/* sv/pulse_actuator_request_scheduler.sv */
// Top level of the pulse actuator request scheduler.
// Each request is either a time tick or a position request for one actuator, and
// each one yields one result: the drive enable, address and position and the
// mask of waiting requests as they stand after it. When a request is taken,
// its result appears on the next cycle; the result lives in the state
// registers themselves, so a new request is accepted in the same cycle the held
// result is taken, giving one request per cycle when the output side keeps up.
// Requests for an actuator at or above NUM_ACTUATORS are ignored. The pulse
// length register (reset 50 ticks) is always ready to be written and applies
// from the next pulse start; a length of zero ends the pulse at the next tick.
module pulse_actuator_request_scheduler #(
  parameter int NUM_ACTUATORS = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_cmd,
  input  logic [pars_pkg::ACT_W-1:0]   in_actuator,
  input  logic                         in_target_position,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_drive_enable,
  output logic [pars_pkg::ACT_W-1:0]   out_drive_address,
  output logic                         out_drive_position,
  output logic [pars_pkg::MASK_W-1:0]  out_pending_mask,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pars_pkg::TICKS_W-1:0] cfg_pulse_ticks
);

  pars_pkg::pars_cmd_t dp_cmd;

  assign cfg_ready = 1'b1;

  pars_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_cmd    (dp_cmd)
  );

  pars_dp #(
    .NUM_ACTUATORS (NUM_ACTUATORS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .dp_cmd             (dp_cmd),
    .in_actuator        (in_actuator),
    .in_target_position (in_target_position),
    .cfg_wr             (cfg_valid && cfg_ready),
    .cfg_data           (cfg_pulse_ticks),
    .drive_enable       (out_drive_enable),
    .drive_address      (out_drive_address),
    .drive_position     (out_drive_position),
    .pending_mask       (out_pending_mask)
  );

  // Every accepted request leaves a result waiting.
  a_accept_gives_result: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid
  ) else $error("accepted request produced no result");

  // A position request never clears a waiting slot.
  a_request_keeps_pending: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_cmd == pars_pkg::CMD_REQUEST) |=>
      ((out_pending_mask & $past(out_pending_mask)) == $past(out_pending_mask))
  ) else $error("request cleared a pending slot");

  // Only a tick may start a pulse.
  a_pulse_start_on_tick: assert property (
    @(posedge clk) disable iff (!rst_n)
    $rose(out_drive_enable) |->
      $past(in_valid && in_ready && in_cmd == pars_pkg::CMD_TICK)
  ) else $error("pulse started without a tick");

endmodule

/* dv/pulse_actuator_request_scheduler_test.sv */
// Self-checking testbench for the pulse actuator request scheduler.
module pulse_actuator_request_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_ACT       = 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;

  typedef struct packed {
    logic                       cmd;
    logic [pars_pkg::ACT_W-1:0] actuator;
    logic                       position;
  } req_item_t;

  typedef struct packed {
    logic                        enable;
    logic [pars_pkg::ACT_W-1:0]  address;
    logic                        position;
    logic [pars_pkg::MASK_W-1:0] mask;
  } drive_word_t;

  logic                         clk;
  logic                         rst_n              = 1'b0;
  logic                         in_valid           = 1'b0;
  logic                         in_ready;
  logic                         in_cmd             = pars_pkg::CMD_TICK;
  logic [pars_pkg::ACT_W-1:0]   in_actuator        = '0;
  logic                         in_target_position = 1'b0;
  logic                         out_valid;
  logic                         out_ready          = 1'b0;
  logic                         out_drive_enable;
  logic [pars_pkg::ACT_W-1:0]   out_drive_address;
  logic                         out_drive_position;
  logic [pars_pkg::MASK_W-1:0]  out_pending_mask;
  logic                         cfg_valid          = 1'b0;
  logic                         cfg_ready;
  logic [pars_pkg::TICKS_W-1:0] cfg_pulse_ticks    = '0;

  // Scheduler state as the testbench expects it.
  logic [pars_pkg::TICKS_W-1:0] pulse_len    = pars_pkg::PULSE_TICKS_RST;
  logic [pars_pkg::TICKS_W-1:0] ticks_left   = '0;
  logic [pars_pkg::ACT_W-1:0]   cur_act      = '0;
  logic                         cur_pos      = 1'b0;
  logic                         drive_on     = 1'b0;
  logic [N_ACT-1:0]             slot_waiting = '0;
  logic [N_ACT-1:0]             slot_pos     = '0;

  req_item_t   request_backlog[$];
  drive_word_t predicted_drive[$];

  int          send_idle_pct = 37;
  int          recv_idle_pct = 63;
  int          fail_count    = 0;
  int unsigned results_seen  = 0;
  int unsigned hold_left     = 0;

  pulse_actuator_request_scheduler #(
    .NUM_ACTUATORS(N_ACT)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_actuator       (in_actuator),
    .in_target_position(in_target_position),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_drive_enable  (out_drive_enable),
    .out_drive_address (out_drive_address),
    .out_drive_position(out_drive_position),
    .out_pending_mask  (out_pending_mask),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_pulse_ticks   (cfg_pulse_ticks)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one accepted request to the expected state and record the drive word after it.
  function automatic void advance_schedule(req_item_t r);
    drive_word_t w;
    bit          started;
    started = 1'b0;
    if (r.cmd == pars_pkg::CMD_TICK) begin
      if (ticks_left != 0) begin
        ticks_left = ticks_left - pars_pkg::TICKS_W'(1);
      end
      if (ticks_left == 0) begin
        for (int i = 0; i < N_ACT; i++) begin
          if (!started && slot_waiting[i]) begin
            slot_waiting[i] = 1'b0;
            cur_act         = pars_pkg::ACT_W'(i);
            cur_pos         = slot_pos[i];
            ticks_left      = pulse_len;
            started         = 1'b1;
          end
        end
        drive_on = started;
      end
    end else if (int'(r.actuator) < N_ACT &&
                 !(ticks_left != 0 && r.actuator == cur_act && r.position == cur_pos)) begin
      slot_waiting[r.actuator] = 1'b1;
      slot_pos[r.actuator]     = r.position;
    end
    w.enable   = drive_on;
    w.address  = cur_act;
    w.position = cur_pos;
    w.mask     = pars_pkg::MASK_W'(slot_waiting);
    predicted_drive.push_back(w);
  endfunction

  function automatic req_item_t random_request();
    req_item_t r;
    r.cmd      = ($urandom_range(1) == 0) ? pars_pkg::CMD_TICK : pars_pkg::CMD_REQUEST;
    r.actuator = pars_pkg::ACT_W'($urandom_range(N_ACT - 1));
    r.position = 1'($urandom_range(1));
    return r;
  endfunction

  // Request driver.
  always @(posedge clk) begin : driver
    req_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        advance_schedule('{cmd: in_cmd, actuator: in_actuator, position: in_target_position});
      end
      if (!in_valid || in_ready) begin
        if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = request_backlog.pop_front();
          in_valid           <= 1'b1;
          in_cmd             <= nxt.cmd;
          in_actuator        <= nxt.actuator;
          in_target_position <= nxt.position;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor; it also throttles the output side.
  always @(posedge clk) begin : monitor
    drive_word_t exp_w;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_left != 0) begin
        hold_left--;
      end
      if (out_valid && out_ready) begin
        if (predicted_drive.size() == 0) begin
          $error("result arrived with no prediction pending");
          fail_count++;
        end else begin
          exp_w = predicted_drive.pop_front();
          if (out_drive_enable !== exp_w.enable) begin
            $error("drive_enable: expected %0d, got %0d", exp_w.enable, out_drive_enable);
            fail_count++;
          end
          if (out_drive_address !== exp_w.address) begin
            $error("drive_address: expected %0d, got %0d", exp_w.address, out_drive_address);
            fail_count++;
          end
          if (out_drive_position !== exp_w.position) begin
            $error("drive_position: expected %0d, got %0d", exp_w.position,
                   out_drive_position);
            fail_count++;
          end
          if (out_pending_mask !== exp_w.mask) begin
            $error("pending_mask: expected %0h, got %0h", exp_w.mask, out_pending_mask);
            fail_count++;
          end
        end
        results_seen++;
        // Stall the output for a long stretch so the scheduler backs up its input.
        if (results_seen == 200 || results_seen == 800) begin
          hold_left = HOLD_CYCLES;
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic queue_request(logic cmd, logic [pars_pkg::ACT_W-1:0] act, logic pos);
    request_backlog.push_back('{cmd: cmd, actuator: act, position: pos});
  endtask

  task automatic queue_junk_tick();
    queue_request(pars_pkg::CMD_TICK, pars_pkg::ACT_W'($urandom_range(N_ACT - 1)),
                  1'($urandom_range(1)));
  endtask

  task automatic wait_for_drain();
    while (request_backlog.size() != 0 || in_valid || predicted_drive.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_pulse_length(logic [pars_pkg::TICKS_W-1:0] len);
    @(posedge clk);
    cfg_valid       <= 1'b1;
    cfg_pulse_ticks <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pulse_len = len;
  endtask

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** pulse_actuator_request_scheduler: FAILED **");
    $finish;
  end

  initial begin : stimulus
    logic [pars_pkg::TICKS_W-1:0] phase_len [8];
    int                           phase_items;
    phase_len = '{16'd1, 16'd3, 16'd2, pars_pkg::TICKS_W'($urandom_range(1, 12)),
                  16'd1, 16'd5, 16'd4, 16'hFFFF};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // With the reset length a pulse must last exactly 50 ticks.
    queue_request(pars_pkg::CMD_REQUEST, 2'd2, 1'b1);
    queue_junk_tick();
    queue_request(pars_pkg::CMD_REQUEST, 2'd2, 1'b1);
    queue_request(pars_pkg::CMD_REQUEST, 2'd0, 1'b0);
    repeat (49) queue_junk_tick();
    wait_for_drain();
    // A new length written mid-pulse only takes effect at the next start.
    write_pulse_length(16'd2);
    queue_junk_tick();

    // Fill every slot, replace one, and drop a request matching the running pulse.
    queue_request(pars_pkg::CMD_REQUEST, 2'd0, 1'b0);
    queue_request(pars_pkg::CMD_REQUEST, 2'd0, 1'b1);
    queue_request(pars_pkg::CMD_REQUEST, 2'd3, 1'b0);
    queue_request(pars_pkg::CMD_REQUEST, 2'd3, 1'b1);
    queue_request(pars_pkg::CMD_REQUEST, 2'd1, 1'b1);
    queue_request(pars_pkg::CMD_REQUEST, 2'd2, 1'b0);
    // Drain in priority order until the enable drops, then tick once while idle.
    repeat (11) queue_junk_tick();
    queue_request(pars_pkg::CMD_REQUEST, 2'd1, 1'b0);
    queue_junk_tick();
    queue_request(pars_pkg::CMD_REQUEST, 2'd1, 1'b0);
    wait_for_drain();

    for (int p = 0; p < 8; p++) begin
      write_pulse_length(phase_len[p]);
      if (p < 3) begin
        send_idle_pct = 37;
        recv_idle_pct = 63;
      end else if (p < 6) begin
        send_idle_pct = 63;
        recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      phase_items = (p == 7) ? 60 : 156;
      for (int n = 0; n < phase_items / 2; n++) begin
        request_backlog.push_back(random_request());
      end
      // Let every outstanding result come back before resuming.
      wait_for_drain();
      for (int n = 0; n < phase_items - phase_items / 2; n++) begin
        request_backlog.push_back(random_request());
      end
      wait_for_drain();
    end

    repeat (5) @(posedge clk);
    if (fail_count == 0 && predicted_drive.size() == 0) begin
      $display("** pulse_actuator_request_scheduler: PASSED **");
    end else begin
      $display("** pulse_actuator_request_scheduler: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/pars_pkg.sv
sv/pars_ctrl.sv
sv/pars_dp.sv
sv/pulse_actuator_request_scheduler.sv
dv/pulse_actuator_request_scheduler_test.sv
